/* rtl/kfg_pkg.sv */
// Shared types, codes and helpers for the video stream keyframe gate.
package kfg_pkg;

    // Field widths fixed by the interface
    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 4;
    localparam int CODEC_W   = 2;
    localparam int FRAME_W   = 64;
    localparam int CNT_W     = 8;
    localparam int VERDICT_W = 3;

    // Defaults and sizes
    localparam int DEFAULT_STREAM_SLOTS = 16;
    localparam int QUEUE_DEPTH          = 2;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic       REG_RERQ   = 1'b0;
    localparam logic       REG_FAIL   = 1'b1;
    localparam logic [CNT_W-1:0] RERQ_RESET = 8'd16;
    localparam logic [CNT_W-1:0] FAIL_RESET = 8'd4;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ANNOUNCE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WATCH    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNIT     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd3;

    // Codec kinds
    localparam logic [CODEC_W-1:0] CODEC_UNSET = 2'd0;
    localparam logic [CODEC_W-1:0] CODEC_TILES = 2'd1;
    localparam logic [CODEC_W-1:0] CODEC_INTER = 2'd2;

    // Verdicts
    localparam logic [VERDICT_W-1:0] V_OK        = 3'd0;
    localparam logic [VERDICT_W-1:0] V_UNKNOWN   = 3'd1;
    localparam logic [VERDICT_W-1:0] V_UNWATCHED = 3'd2;
    localparam logic [VERDICT_W-1:0] V_STALE     = 3'd3;
    localparam logic [VERDICT_W-1:0] V_FROZEN    = 3'd4;
    localparam logic [VERDICT_W-1:0] V_GAP       = 3'd5;
    localparam logic [VERDICT_W-1:0] V_FAILED    = 3'd6;
    localparam logic [VERDICT_W-1:0] V_DONE      = 3'd7;

    // One classified command between front and back
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SLOT_W-1:0]  slot;
        logic               in_range;
        logic [CODEC_W-1:0] codec;
        logic               watch;
        logic [FRAME_W-1:0] frame;
        logic               key;
        logic               dec_ok;
    } t_item;

    // Per-slot record held in the table memory
    typedef struct packed {
        logic               watching;
        logic [CODEC_W-1:0] codec;
        logic [FRAME_W-1:0] last_good;
        logic               has_decoded;
        logic               awaiting_key;
        logic [CNT_W-1:0]   frozen_cnt;
        logic [CNT_W-1:0]   failure_cnt;
    } t_rec;

    // Saturating increment of an event counter
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
        return r;
    endfunction

endpackage

/* rtl/kfg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/kfg_front.sv */
// Front end: classify an incoming command before it is queued.
module kfg_front #(
    parameter int STREAM_SLOTS = kfg_pkg::DEFAULT_STREAM_SLOTS
) (
    input  logic [kfg_pkg::CMD_W-1:0]   i_command,
    input  logic [kfg_pkg::SLOT_W-1:0]  i_stream_slot,
    input  logic [kfg_pkg::CODEC_W-1:0] i_codec_kind,
    input  logic                        i_watch_flag,
    input  logic [kfg_pkg::FRAME_W-1:0] i_frame_number,
    input  logic                        i_is_keyframe,
    input  logic                        i_decode_ok,
    output kfg_pkg::t_item              o_item
);

    // Flag slots beyond the table and pack the command
    always_comb begin
        o_item          = '0;
        o_item.cmd      = i_command;
        o_item.slot     = i_stream_slot;
        o_item.in_range = (32'(i_stream_slot) < STREAM_SLOTS);
        o_item.codec    = i_codec_kind;
        o_item.watch    = i_watch_flag;
        o_item.frame    = i_frame_number;
        o_item.key      = i_is_keyframe;
        o_item.dec_ok   = i_decode_ok;
    end

endmodule

/* rtl/kfg_queue.sv */
// Short queue that decouples the front end from the back end.
module kfg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kfg_pkg::t_item i_item,
    input  logic           i_pop,
    output kfg_pkg::t_item o_head,
    output logic           o_full,
    output logic           o_empty
);

    localparam int DEPTH = kfg_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    kfg_pkg::t_item r_buf [DEPTH];
    logic [PW-1:0]  r_wptr, n_wptr;
    logic [PW-1:0]  r_rptr, n_rptr;
    logic [CW-1:0]  r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_buf[r_rptr];

    // Advance pointers with wrap
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_item;
        end
    end

endmodule

/* rtl/kfg_back.sv */
// Back end: per-slot table read-modify-write and the result register.
module kfg_back #(
    parameter int STREAM_SLOTS = kfg_pkg::DEFAULT_STREAM_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [kfg_pkg::CNT_W-1:0]     i_rerequest_after_units,
    input  logic [kfg_pkg::CNT_W-1:0]     i_request_after_failures,
    input  kfg_pkg::t_item                i_head,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_pass_unit,
    output logic                          o_keyframe_request,
    output logic [kfg_pkg::VERDICT_W-1:0] o_verdict
);

    localparam int AW    = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
    localparam int REC_W = $bits(kfg_pkg::t_rec);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                    r_state, n_state;
    kfg_pkg::t_item          r_item;
    logic [STREAM_SLOTS-1:0] r_vbits;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_pass;
    logic                    r_out_req;
    logic [kfg_pkg::VERDICT_W-1:0] r_out_verdict;

    logic [REC_W-1:0]        ram_rdata;
    kfg_pkg::t_rec           rd;
    kfg_pkg::t_rec           rec_n;
    logic [AW-1:0]           raddr;
    logic [AW-1:0]           idx;
    logic                    commit;
    logic                    we;
    logic                    vbit_set;
    logic                    vbit_clr;
    logic                    pass;
    logic                    req;
    logic [kfg_pkg::VERDICT_W-1:0] verdict;

    assign raddr  = AW'(i_head.slot);
    assign idx    = AW'(r_item.slot);
    assign rd     = kfg_pkg::t_rec'(ram_rdata);
    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign commit = (r_state == S_EXEC) && (!r_out_valid || !i_stall);

    kfg_ram #(
        .WIDTH (REC_W),
        .DEPTH (STREAM_SLOTS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (commit && we),
        .i_waddr (idx),
        .i_wdata (REC_W'(rec_n)),
        .i_re    (o_pop),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // Execute the command against the slot record
    always_comb begin
        logic                          vbit;
        logic [kfg_pkg::FRAME_W:0]     diff;
        logic                          stale;
        logic                          next_ok;
        logic                          inter;
        logic                          decodable;
        logic                          done;
        logic [kfg_pkg::CNT_W-1:0]     frz;
        logic [kfg_pkg::CNT_W-1:0]     fail;

        vbit      = r_item.in_range ? r_vbits[idx] : 1'b0;
        diff      = {1'b0, r_item.frame} - {1'b0, rd.last_good};
        stale     = diff[kfg_pkg::FRAME_W] || (diff[kfg_pkg::FRAME_W-1:0] == '0);
        next_ok   = (diff[kfg_pkg::FRAME_W-1:0] == kfg_pkg::FRAME_W'(1));
        inter     = (rd.codec == kfg_pkg::CODEC_INTER);
        decodable = (rd.codec == kfg_pkg::CODEC_TILES) || inter;
        frz       = kfg_pkg::sat_inc(rd.frozen_cnt);
        fail      = kfg_pkg::sat_inc(rd.failure_cnt);
        done      = 1'b0;

        rec_n    = rd;
        we       = 1'b0;
        vbit_set = 1'b0;
        vbit_clr = 1'b0;
        pass     = 1'b0;
        req      = 1'b0;
        verdict  = kfg_pkg::V_DONE;

        if (!r_item.in_range) begin
            verdict = kfg_pkg::V_UNKNOWN;
        end else begin
            unique case (r_item.cmd)
                kfg_pkg::CMD_ANNOUNCE: begin
                    we = 1'b1;
                    if (!vbit) begin
                        rec_n    = '0;
                        vbit_set = 1'b1;
                    end else if (rd.codec != r_item.codec) begin
                        rec_n.last_good    = '0;
                        rec_n.has_decoded  = 1'b0;
                        rec_n.awaiting_key = 1'b0;
                        rec_n.frozen_cnt   = '0;
                    end
                    rec_n.codec = r_item.codec;
                end
                kfg_pkg::CMD_WATCH: begin
                    if (!vbit) begin
                        verdict = kfg_pkg::V_UNKNOWN;
                    end else begin
                        we             = 1'b1;
                        rec_n.watching = r_item.watch;
                    end
                end
                kfg_pkg::CMD_REMOVE: begin
                    if (!vbit) begin
                        verdict = kfg_pkg::V_UNKNOWN;
                    end else begin
                        vbit_clr = 1'b1;
                    end
                end
                kfg_pkg::CMD_UNIT: begin
                    if (!vbit) begin
                        verdict = kfg_pkg::V_UNKNOWN;
                    end else if (!rd.watching) begin
                        verdict = kfg_pkg::V_UNWATCHED;
                    end else begin
                        we = 1'b1;
                        // Continuity checks for inter-frame streams
                        if (inter && rd.has_decoded) begin
                            if (stale) begin
                                verdict = kfg_pkg::V_STALE;
                                done    = 1'b1;
                            end else if (rd.awaiting_key && !r_item.key) begin
                                if (frz >= i_rerequest_after_units) begin
                                    rec_n.frozen_cnt = '0;
                                    req              = 1'b1;
                                end else begin
                                    rec_n.frozen_cnt = frz;
                                end
                                verdict = kfg_pkg::V_FROZEN;
                                done    = 1'b1;
                            end else if (!r_item.key && !next_ok) begin
                                rec_n.awaiting_key = 1'b1;
                                rec_n.frozen_cnt   = '0;
                                req                = 1'b1;
                                verdict            = kfg_pkg::V_GAP;
                                done               = 1'b1;
                            end
                        end
                        // Decode outcome
                        if (!done) begin
                            if (!decodable || !r_item.dec_ok) begin
                                if (decodable) begin
                                    if (fail >= i_request_after_failures) begin
                                        rec_n.failure_cnt = '0;
                                        req               = 1'b1;
                                    end else begin
                                        rec_n.failure_cnt = fail;
                                    end
                                end
                                verdict = kfg_pkg::V_FAILED;
                            end else begin
                                rec_n.failure_cnt = '0;
                                if (inter) begin
                                    rec_n.last_good    = r_item.frame;
                                    rec_n.has_decoded  = 1'b1;
                                    rec_n.awaiting_key = 1'b0;
                                    rec_n.frozen_cnt   = '0;
                                end
                                pass    = 1'b1;
                                verdict = kfg_pkg::V_OK;
                            end
                        end
                    end
                end
                default: begin
                    verdict = kfg_pkg::V_DONE;
                end
            endcase
        end
    end

    // Sequence: take an item, then execute once the result register is free
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_vbits     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (commit && vbit_set) begin
                r_vbits[idx] <= 1'b1;
            end else if (commit && vbit_clr) begin
                r_vbits[idx] <= 1'b0;
            end
        end
    end

    // Hold the item and the result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
        if (commit) begin
            r_out_pass    <= pass;
            r_out_req     <= req;
            r_out_verdict <= verdict;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_pass_unit        = r_out_pass;
    assign o_keyframe_request = r_out_req;
    assign o_verdict          = r_out_verdict;

endmodule

/* rtl/video_stream_keyframe_gate.sv */
// Top level of the video stream keyframe gate: config port, front, queue, back.
//
// Each transfer on the input channel is a command for one stream slot
// (announce, set watching, video unit, remove) and yields exactly one result
// transfer carrying pass_unit, keyframe_request and a verdict. The front end
// classifies commands into a two-entry queue; the back end takes one command
// at a time: a registered read of the slot record from the table memory, then,
// once the result register is free, evaluation of the unit rules and the write
// back of the record. The queue lets the input keep taking transfers while a
// result waits on a stalled output. Slot validity lives in flip-flops cleared
// by reset, so the block is ready immediately after reset with no clearing
// pass. The two thresholds sit at byte addresses 0 and 4; the user must see
// that they are written only while idle, as the block has no check for it.
module video_stream_keyframe_gate #(
    parameter int STREAM_SLOTS = kfg_pkg::DEFAULT_STREAM_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [kfg_pkg::CMD_W-1:0]     i_command,
    input  logic [kfg_pkg::SLOT_W-1:0]    i_stream_slot,
    input  logic [kfg_pkg::CODEC_W-1:0]   i_codec_kind,
    input  logic                          i_watch_flag,
    input  logic [kfg_pkg::FRAME_W-1:0]   i_frame_number,
    input  logic                          i_is_keyframe,
    input  logic                          i_decode_ok,
    // Output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_pass_unit,
    output logic                          o_keyframe_request,
    output logic [kfg_pkg::VERDICT_W-1:0] o_verdict,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kfg_pkg::PADDR_W-1:0]   paddr,
    input  logic [kfg_pkg::PDATA_W-1:0]   pwdata,
    output logic [kfg_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [kfg_pkg::CNT_W-1:0] r_rerequest_after_units;
    logic [kfg_pkg::CNT_W-1:0] r_request_after_failures;
    logic                      cfg_wr;
    kfg_pkg::t_item            front_item;
    kfg_pkg::t_item            q_head;
    logic                      q_full;
    logic                      q_empty;
    logic                      q_push;
    logic                      q_pop;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rerequest_after_units  <= kfg_pkg::RERQ_RESET;
            r_request_after_failures <= kfg_pkg::FAIL_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                kfg_pkg::REG_RERQ: r_rerequest_after_units  <= pwdata[kfg_pkg::CNT_W-1:0];
                kfg_pkg::REG_FAIL: r_request_after_failures <= pwdata[kfg_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (paddr[2])
            kfg_pkg::REG_RERQ: prdata = kfg_pkg::PDATA_W'(r_rerequest_after_units);
            kfg_pkg::REG_FAIL: prdata = kfg_pkg::PDATA_W'(r_request_after_failures);
            default:           prdata = '0;
        endcase
    end

    // Accept a transfer whenever the queue has room
    assign o_stall = q_full;
    assign q_push  = i_valid && !q_full;

    kfg_front #(
        .STREAM_SLOTS (STREAM_SLOTS)
    ) u_front (
        .i_command      (i_command),
        .i_stream_slot  (i_stream_slot),
        .i_codec_kind   (i_codec_kind),
        .i_watch_flag   (i_watch_flag),
        .i_frame_number (i_frame_number),
        .i_is_keyframe  (i_is_keyframe),
        .i_decode_ok    (i_decode_ok),
        .o_item         (front_item)
    );

    kfg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    kfg_back #(
        .STREAM_SLOTS (STREAM_SLOTS)
    ) u_back (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_rerequest_after_units  (r_rerequest_after_units),
        .i_request_after_failures (r_request_after_failures),
        .i_head                   (q_head),
        .i_empty                  (q_empty),
        .o_pop                    (q_pop),
        .o_valid                  (o_valid),
        .i_stall                  (i_stall),
        .o_pass_unit              (o_pass_unit),
        .o_keyframe_request       (o_keyframe_request),
        .o_verdict                (o_verdict)
    );

`ifndef SYNTHESIS
    // The back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // A passed unit always carries the ok verdict
    a_pass_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pass_unit) |-> (o_verdict == kfg_pkg::V_OK && !o_keyframe_request))
        else $error("pass without ok verdict");

    // A keyframe request comes only with a frozen, gap or decode-failed drop
    a_req_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_keyframe_request) |->
            (o_verdict == kfg_pkg::V_FROZEN || o_verdict == kfg_pkg::V_GAP ||
             o_verdict == kfg_pkg::V_FAILED))
        else $error("keyframe request without a cause");

    // A result is only raised after an item was taken from the queue
    a_result_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(q_pop, 2) || $past(!q_empty, 2) || $past(o_valid, 1) == 1'b0)
        else $error("result without a queued item");
`endif

endmodule
